FILE: hdl/twm_pkg.sv
// shared types and constants for the tolerance window matcher
// used by twm_ctrl, twm_datapath and tolerance_window_matcher; no dependencies
`default_nettype none

package twm_pkg;

   localparam int VALUE_W     = 30;
   localparam int TOL_W       = 30;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int QIDX_W      = 10;
   localparam int CIDX_W      = 10;
   localparam int COUNT_W     = 11;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_TOL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_TOL = 1'd1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic clear;
      logic advance;
      logic finish;
      logic hit;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic ptr_lt_count;
      logic above_hi;
      logic reach_lo;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/twm_ctrl.sv
// controller state machine for the tolerance window matcher
// depends on twm_pkg; drives commands into twm_datapath
`default_nettype none

module twm_ctrl
   import twm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [OP_W-1:0] req_op,
   input  wire status_type      status,
   output cmd_type              cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (op_type'(req_op))
                  OP_LOAD:  cmd.load = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_QUERY: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // one candidate per cycle: stop past the window or after the last candidate, take one inside it
            if (!status.ptr_lt_count || status.above_hi) begin
               cmd.finish = 1'b1;
               state_in   = ST_DELIVER;
            end else if (status.reach_lo) begin
               cmd.finish  = 1'b1;
               cmd.hit     = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_DELIVER;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/twm_datapath.sv
// datapath: candidate memory, pointer and counters, window compare, result register
// depends on twm_pkg; controlled by twm_ctrl
`default_nettype none

module twm_datapath
   import twm_pkg::*;
#(
   parameter int MAX_ITEMS = 1024
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [VALUE_W-1:0]     req_value,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TOL_W-1:0]       csr_wdata,
   input  wire cmd_type                cmd,
   output status_type                  status,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic                        rsp_matched,
   output logic [QIDX_W-1:0]           rsp_query_index,
   output logic [CIDX_W-1:0]           rsp_candidate_index,
   output logic [COUNT_W-1:0]          rsp_pair_count
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] CAPACITY = CW'(MAX_ITEMS);

   logic [VALUE_W-1:0] mem [MAX_ITEMS];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [TOL_W-1:0]   lower_tol_ff;
   logic [TOL_W-1:0]   upper_tol_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [COUNT_W-1:0] query_count_ff, query_count_in;
   logic [COUNT_W-1:0] pairs_ff, pairs_in;
   logic signed [VALUE_W+1:0] lo_ff;
   logic [VALUE_W:0]   hi_ff;
   logic               hit_ff;
   logic [AW-1:0]      where_ff;
   logic               rsp_valid_ff;
   logic               store_full;
   logic [31:0]        where_wide;

   assign store_full = (count_ff >= CAPACITY);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_tol_ff <= '0;
         upper_tol_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LOWER_TOL: lower_tol_ff <= csr_wdata;
            REG_UPPER_TOL: upper_tol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      query_count_in = query_count_ff;
      pairs_in       = pairs_ff;
      if (cmd.clear) begin
         count_in       = '0;
         ptr_in         = '0;
         query_count_in = '0;
         pairs_in       = '0;
      end
      if (cmd.load && !store_full) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.advance) begin
         ptr_in = ptr_ff + CW'(1);
      end
      if (cmd.deliver) begin
         if (hit_ff && (pairs_ff != COUNT_MAX)) begin
            pairs_in = pairs_ff + COUNT_W'(1);
         end
         if (query_count_ff != COUNT_MAX) begin
            query_count_in = query_count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         ptr_ff         <= '0;
         query_count_ff <= '0;
         pairs_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         ptr_ff         <= ptr_in;
         query_count_ff <= query_count_in;
         pairs_ff       <= pairs_in;
         if (cmd.deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // read follows the next pointer so data for the current pointer is ready
   always_ff @(posedge clock) begin
      if (cmd.load && !store_full) begin
         mem[count_ff[AW-1:0]] <= req_value;
      end
      rd_data_ff <= mem[ptr_in[AW-1:0]];
   end

   // window bounds taken once per query
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff <= $signed({2'b00, req_value}) - $signed({2'b00, lower_tol_ff});
         hi_ff <= {1'b0, req_value} + {1'b0, upper_tol_ff};
      end
      if (cmd.finish) begin
         hit_ff   <= cmd.hit;
         where_ff <= ptr_ff[AW-1:0];
      end
   end

   assign where_wide = 32'(where_ff);

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_matched         <= hit_ff;
         rsp_query_index     <= query_count_ff[QIDX_W-1:0];
         rsp_candidate_index <= hit_ff ? where_wide[CIDX_W-1:0] : '0;
         rsp_pair_count      <= pairs_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      status.ptr_lt_count = (ptr_ff < count_ff);
      status.above_hi     = ({1'b0, rd_data_ff} > hi_ff);
      status.reach_lo     = ($signed({2'b00, rd_data_ff}) >= lo_ff);
      status.out_free     = !rsp_valid_ff || rsp_tready;
   end

   a_ptr_within_count: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("candidate pointer passed the candidate count");

   a_count_within_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY)
      else $error("candidate count exceeds capacity");

   a_advance_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (ptr_ff < count_ff))
      else $error("pointer advanced past the loaded candidates");

   a_deliver_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a pending transfer");

endmodule

`default_nettype wire

FILE: hdl/tolerance_window_matcher.sv
// tolerance window matcher: top level joining controller and datapath
// depends on twm_pkg, twm_ctrl and twm_datapath
//
// req channel carries one item per transfer: tuser is the op (load, query,
// clear), tdata the 30-bit value. rsp channel gives one result per query:
// tuser is the matched flag, tdata the query index, candidate index and pair
// count. csr_we/csr_index/csr_wdata write the lower and upper tolerance;
// the user must write them only while the block is idle; the block does not enforce it.
// load and clear are done in the idle state. a query takes the block through
// the scan and deliver states before it takes the next item; the scan
// reads one stored candidate per cycle through the single read port of the
// candidate memory, and the deliver state writes the result register.
// reset clears the counters, the pointer and both tolerances; the candidate
// memory is not cleared, only entries below the fill count are read.
// if the receiver stalls, the result waits in the output register; the block
// still takes loads and clears, and a following query waits before its
// result until the register is free.
`default_nettype none

module tolerance_window_matcher
   import twm_pkg::*;
#(
   parameter int MAX_ITEMS = 1024
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // [29:0] value
   input  wire logic [OP_W-1:0]        req_tuser,   // [1:0] op
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [9:0] query_index,
                                                    // [19:10] candidate_index,
                                                    // [30:20] pair_count
   output logic                        rsp_tuser,   // [0] matched
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TOL_W-1:0]       csr_wdata
);

   cmd_type            cmd;
   status_type         status;
   logic [QIDX_W-1:0]  query_index;
   logic [CIDX_W-1:0]  candidate_index;
   logic [COUNT_W-1:0] pair_count;

   twm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   twm_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_value           (req_tdata[VALUE_W-1:0]),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_matched         (rsp_tuser),
      .rsp_query_index     (query_index),
      .rsp_candidate_index (candidate_index),
      .rsp_pair_count      (pair_count)
   );

   assign rsp_tdata = {1'b0, pair_count, candidate_index, query_index};

endmodule

`default_nettype wire
